// File: hdl/assert_macros.svh
// Assertion macros used by the checker file, cim_checker.sv.
// Needs nothing else; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define CIM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cim assertion failed");

// Next-cycle implication, off while reset is low.
`define CIM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cim assertion failed");

`endif

// File: hdl/cim_pkg.sv
// Shared types and constants of the color interest map.
// Depends on nothing; imported by the top level, its checker and the testbench.
`timescale 1ns / 1ps

package cim_pkg;

  localparam int MAX_COLORS  = 4;
  localparam int REF_REGS    = 4;
  localparam int CHANNELS    = 3;
  localparam int TABLE_DEPTH = 256;
  localparam int PIX_W       = 8;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int WT_W        = 8;
  localparam int COLOR_W     = CHANNELS * PIX_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = COLOR_W;
  localparam int SQ_W        = 2 * PIX_W;
  localparam int DIST_W      = SQ_W + 2;
  localparam int BEST_W      = SQ_W;
  localparam int CUT_W       = 9;
  localparam int CUT_SQ_W    = 2 * CUT_W;
  localparam int SQRT_STEPS  = PIX_W;
  localparam int RSQ_W       = SQ_W + 1;

  localparam logic [BEST_W-1:0] START_MIN = BEST_W'(65025);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_COUNT   = 3'd0,
    REG_CHANNEL_COUNT = 3'd1,
    REG_REF_COLOR0    = 3'd2,
    REG_REF_COLOR1    = 3'd3,
    REG_REF_COLOR2    = 3'd4,
    REG_REF_COLOR3    = 3'd5,
    REG_CUTOFF        = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_TABLE = 1'b1
  } func_t;

  typedef struct packed {
    func_t            func;
    logic [IDX_W-1:0] tidx;
    logic [WT_W-1:0]  tval;
  } ctl_t;

endpackage

// File: hdl/color_interest_map_top.sv
// Per-pixel closeness weight to the nearest of up to four reference colors.
// Depends on cim_pkg; holds the weight table as a synchronous RAM.
`timescale 1ns / 1ps

// One word enters per clock while the output is not held off, and a pixel
// result appears once its word has passed the 12 pipeline stages (the first
// loaded at the accepting edge) and then the output register; table writes
// take the same path and leave no result. The rate of one word per cycle is
// set by the single-port 256 x 8 weight RAM that sees at most one access per
// cycle at the memory stage, write or read, in arrival order.
// The pipeline squares channel differences, sums per color, takes the
// minimum, then forms the integer square root one bit per stage. Stages
// fill bubbles while the output waits, so input is taken until every
// stage is full. The table is undefined until written; no clearing pass.
module color_interest_map_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [cim_pkg::PIX_W-1:0]     in_pix_ch0,
  input  logic [cim_pkg::PIX_W-1:0]     in_pix_ch1,
  input  logic [cim_pkg::PIX_W-1:0]     in_pix_ch2,
  input  logic [cim_pkg::IDX_W-1:0]     in_table_index,
  input  logic [cim_pkg::WT_W-1:0]      in_table_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cim_pkg::WT_W-1:0]      out_interest,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cim_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cim_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cim_pkg::*;

  localparam int SQ0   = 0;
  localparam int SUM   = 1;
  localparam int MIN   = 2;
  localparam int RT0   = 3;
  localparam int MEM   = RT0 + SQRT_STEPS;
  localparam int NST   = MEM + 1;

  // configuration
  logic [2:0]          color_count_r;
  logic [1:0]          channel_count_r;
  logic [COLOR_W-1:0]  ref_r [REF_REGS];
  logic [CUT_W-1:0]    cutoff_r;
  logic [CUT_SQ_W-1:0] cutoff_sq_r;

  // pipeline control
  logic                v_r [NST];
  logic                rdy [NST];
  logic                rdy_out;
  ctl_t                ctl_r [NST];

  // datapath stages
  logic [SQ_W-1:0]     sq_r   [REF_REGS][CHANNELS];
  logic [REF_REGS-1:0] en_sq_r;
  logic [DIST_W-1:0]   dist_r [REF_REGS];
  logic [REF_REGS-1:0] en_sum_r;
  logic [BEST_W-1:0]   best_r;
  logic [BEST_W-1:0]   val_r  [SQRT_STEPS];
  logic [PIX_W-1:0]    root_r [SQRT_STEPS];
  logic [RSQ_W-1:0]    rsq_r  [SQRT_STEPS];
  logic                rej_r  [SQRT_STEPS];
  logic                rej_m_r;
  logic [WT_W-1:0]     rd_q_r;
  logic [WT_W-1:0]     wt_mem [TABLE_DEPTH];

  logic                out_valid_r;
  logic [WT_W-1:0]     out_interest_r;

  // next values
  logic [SQ_W-1:0]     sq_nxt   [REF_REGS][CHANNELS];
  logic [REF_REGS-1:0] en_sq_nxt;
  logic [DIST_W-1:0]   dist_nxt [REF_REGS];
  logic [BEST_W-1:0]   best_nxt;
  logic [BEST_W-1:0]   val_in   [SQRT_STEPS];
  logic [PIX_W-1:0]    root_in  [SQRT_STEPS];
  logic [RSQ_W-1:0]    rsq_in   [SQRT_STEPS];
  logic                rej_in   [SQRT_STEPS];
  logic [PIX_W-1:0]    root_nxt [SQRT_STEPS];
  logic [RSQ_W-1:0]    rsq_nxt  [SQRT_STEPS];
  ctl_t                ctl_in;
  logic                mem_en;
  logic [IDX_W-1:0]    mem_addr;

  function automatic logic dist_nxt_cmp(input logic [DIST_W-1:0] a,
                                        input logic [BEST_W-1:0] b);
    return a < DIST_W'(b);
  endfunction

  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_interest = out_interest_r;
  assign in_ready     = rdy[0];

  assign ctl_in.func = func_t'(in_func);
  assign ctl_in.tidx = in_table_index;
  assign ctl_in.tval = in_table_value;

  // ready chain: a stage loads when empty or when its word moves on
  always_comb begin
    rdy_out  = !out_valid_r || out_ready;
    rdy[NST-1] = !v_r[NST-1] || rdy_out;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_count_r   <= 3'd1;
      channel_count_r <= 2'd3;
      for (int n = 0; n < REF_REGS; n++) begin
        ref_r[n] <= '0;
      end
      cutoff_r        <= CUT_W'(256);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COLOR_COUNT:   color_count_r   <= cfg_data[2:0];
        REG_CHANNEL_COUNT: channel_count_r <= cfg_data[1:0];
        REG_REF_COLOR0:    ref_r[0]        <= cfg_data;
        REG_REF_COLOR1:    ref_r[1]        <= cfg_data;
        REG_REF_COLOR2:    ref_r[2]        <= cfg_data;
        REG_REF_COLOR3:    ref_r[3]        <= cfg_data;
        REG_CUTOFF:        cutoff_r        <= cfg_data[CUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cutoff_sq_r <= CUT_SQ_W'(cutoff_r) * CUT_SQ_W'(cutoff_r);
  end

  // squared channel differences per color
  always_comb begin
    logic [2:0]       cols;
    logic [1:0]       chans;
    logic [PIX_W-1:0] pix [CHANNELS];
    logic [PIX_W-1:0] rc;
    logic [PIX_W-1:0] d;
    cols   = (color_count_r > 3'(MAX_COLORS)) ? 3'(MAX_COLORS) : color_count_r;
    chans  = (channel_count_r == 2'd0) ? 2'd1 : channel_count_r;
    pix[0] = in_pix_ch0;
    pix[1] = in_pix_ch1;
    pix[2] = in_pix_ch2;
    for (int n = 0; n < REF_REGS; n++) begin
      en_sq_nxt[n] = 4'(n) < {1'b0, cols};
      for (int c = 0; c < CHANNELS; c++) begin
        rc = ref_r[n][c*PIX_W +: PIX_W];
        d  = (pix[c] >= rc) ? (pix[c] - rc) : (rc - pix[c]);
        sq_nxt[n][c] = (3'(c) < {1'b0, chans}) ? (SQ_W'(d) * SQ_W'(d)) : '0;
      end
    end
  end

  // per-color sum
  always_comb begin
    for (int n = 0; n < REF_REGS; n++) begin
      dist_nxt[n] = DIST_W'(sq_r[n][0]) + DIST_W'(sq_r[n][1]) + DIST_W'(sq_r[n][2]);
    end
  end

  // running minimum
  always_comb begin
    best_nxt = START_MIN;
    for (int n = 0; n < REF_REGS; n++) begin
      if (en_sum_r[n] && (dist_nxt_cmp(dist_r[n], best_nxt))) begin
        best_nxt = dist_r[n][BEST_W-1:0];
      end
    end
  end

  // square root, one result bit per stage
  always_comb begin
    val_in[0]  = best_r;
    root_in[0] = '0;
    rsq_in[0]  = '0;
    rej_in[0]  = CUT_SQ_W'(best_r) > cutoff_sq_r;
    for (int k = 1; k < SQRT_STEPS; k++) begin
      val_in[k]  = val_r[k-1];
      root_in[k] = root_r[k-1];
      rsq_in[k]  = rsq_r[k-1];
      rej_in[k]  = rej_r[k-1];
    end
  end

  always_comb begin
    logic [PIX_W-1:0] t;
    logic [RSQ_W-1:0] t2;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      t  = root_in[k] | (PIX_W'(1) << (SQRT_STEPS - 1 - k));
      t2 = rsq_in[k] + (RSQ_W'(root_in[k]) << (SQRT_STEPS - k))
           + (RSQ_W'(1) << (2 * (SQRT_STEPS - 1 - k)));
      if (t2 <= RSQ_W'(val_in[k])) begin
        root_nxt[k] = t;
        rsq_nxt[k]  = t2;
      end else begin
        root_nxt[k] = root_in[k];
        rsq_nxt[k]  = rsq_in[k];
      end
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        v_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (rdy_out) begin
        out_valid_r <= v_r[MEM] && (ctl_r[MEM].func == FUNC_PIXEL);
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (rdy[SQ0]) begin
      ctl_r[SQ0] <= ctl_in;
      sq_r       <= sq_nxt;
      en_sq_r    <= en_sq_nxt;
    end
    for (int k = 1; k < NST; k++) begin
      if (rdy[k]) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
    if (rdy[SUM]) begin
      dist_r   <= dist_nxt;
      en_sum_r <= en_sq_r;
    end
    if (rdy[MIN]) begin
      best_r <= best_nxt;
    end
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (rdy[RT0 + k]) begin
        val_r[k]  <= val_in[k];
        root_r[k] <= root_nxt[k];
        rsq_r[k]  <= rsq_nxt[k];
        rej_r[k]  <= rej_in[k];
      end
    end
    if (rdy[MEM]) begin
      rej_m_r <= rej_r[SQRT_STEPS-1];
    end
    if (rdy_out) begin
      out_interest_r <= rej_m_r ? '0 : rd_q_r;
    end
  end

  // weight table: one write or one read per cycle, in word order
  assign mem_en   = rdy[MEM] && v_r[MEM-1];
  assign mem_addr = (ctl_r[MEM-1].func == FUNC_TABLE) ? ctl_r[MEM-1].tidx
                                                       : root_r[SQRT_STEPS-1];

  always_ff @(posedge clk) begin
    if (mem_en) begin
      if (ctl_r[MEM-1].func == FUNC_TABLE) begin
        wt_mem[mem_addr] <= ctl_r[MEM-1].tval;
      end else begin
        rd_q_r <= wt_mem[mem_addr];
      end
    end
  end

endmodule

// File: hdl/cim_checker.sv
// Port-level checks for the color interest map, bound to its top level.
// Depends on cim_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cim_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_func,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cim_pkg::WT_W-1:0]      out_interest,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);
  import cim_pkg::*;

  logic in_word;
  assign in_word = in_valid && in_ready && (in_func == FUNC_PIXEL);

  `CIM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_interest))
  `CIM_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)
  `CIM_ASSERT_NOW(a_reset_out, clk, rst_n, !$past(rst_n), !out_valid)
  `CIM_ASSERT_NEXT(a_no_early_result, clk, rst_n, !$past(rst_n) && in_word, !out_valid)

endmodule

bind color_interest_map_top cim_checker u_cim_checker (.*);

// File: dv/color_interest_map_top_tb.sv
// Testbench for color_interest_map_top: random and directed pixel and table words
// with a scoreboard that predicts each interest value. Depends on cim_pkg and the RTL.
`timescale 1ns / 1ps

module color_interest_map_top_tb;
  import cim_pkg::*;

  localparam int LIMIT        = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 14;
  localparam int PHASE_WORDS  = 110;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  class interest_scoreboard;
    logic [WT_W-1:0]    weights [TABLE_DEPTH];
    logic [2:0]         color_count;
    logic [1:0]         channel_count;
    logic [COLOR_W-1:0] ref_color [REF_REGS];
    logic [CUT_W-1:0]   cutoff;
    logic [WT_W-1:0]    interest_q [$];
    int                 mismatches;

    function new();
      color_count   = 3'd1;
      channel_count = 2'd3;
      cutoff        = 9'd256;
      mismatches    = 0;
      foreach (ref_color[n]) ref_color[n] = '0;
      foreach (weights[i]) weights[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_COLOR_COUNT:   color_count = data[2:0];
        REG_CHANNEL_COUNT: channel_count = data[1:0];
        REG_REF_COLOR0:    ref_color[0] = data;
        REG_REF_COLOR1:    ref_color[1] = data;
        REG_REF_COLOR2:    ref_color[2] = data;
        REG_REF_COLOR3:    ref_color[3] = data;
        REG_CUTOFF:        cutoff = data[CUT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned nearest_dist(logic [PIX_W-1:0] p0, logic [PIX_W-1:0] p1,
                                       logic [PIX_W-1:0] p2);
      int unsigned best;
      int unsigned dsq;
      int          diff;
      int          n_colors;
      int          n_chan;
      logic [PIX_W-1:0] px [CHANNELS];
      px[0] = p0;
      px[1] = p1;
      px[2] = p2;
      best = START_MIN;
      n_colors = (color_count > MAX_COLORS) ? MAX_COLORS : color_count;
      n_chan = (channel_count == 0) ? 1 : channel_count;
      for (int n = 0; n < n_colors; n++) begin
        dsq = 0;
        for (int c = 0; c < n_chan; c++) begin
          diff = int'(px[c]) - int'(ref_color[n][8*c +: 8]);
          dsq += diff * diff;
        end
        if (dsq < best) best = dsq;
      end
      return best;
    endfunction

    function int unsigned root_index(int unsigned dsq);
      int unsigned root;
      int unsigned trial;
      root = 0;
      for (int b = 7; b >= 0; b--) begin
        trial = root | (1 << b);
        if (trial * trial <= dsq) root = trial;
      end
      return root;
    endfunction

    function void note_word(func_t f, logic [PIX_W-1:0] p0, logic [PIX_W-1:0] p1,
                            logic [PIX_W-1:0] p2, logic [IDX_W-1:0] tidx,
                            logic [WT_W-1:0] tval);
      int unsigned dsq;
      if (f == FUNC_TABLE) begin
        weights[tidx] = tval;
      end else begin
        dsq = nearest_dist(p0, p1, p2);
        if (dsq > int'(cutoff) * int'(cutoff)) interest_q.push_back('0);
        else interest_q.push_back(weights[root_index(dsq)]);
      end
    endfunction

    function void check_result(logic [WT_W-1:0] got);
      logic [WT_W-1:0] want;
      if (interest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected interest word %0d", got);
      end else begin
        want = interest_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("interest mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction

    function int pending();
      return interest_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_func;
  logic [PIX_W-1:0]      in_pix_ch0;
  logic [PIX_W-1:0]      in_pix_ch1;
  logic [PIX_W-1:0]      in_pix_ch2;
  logic [IDX_W-1:0]      in_table_index;
  logic [WT_W-1:0]       in_table_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [WT_W-1:0]       out_interest;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  interest_scoreboard sb = new();
  int idle_pct = 35;
  bit rx_hold_req = 0;
  int cycle_count = 0;

  color_interest_map_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_pix_ch0     (in_pix_ch0),
    .in_pix_ch1     (in_pix_ch1),
    .in_pix_ch2     (in_pix_ch2),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_interest   (out_interest),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_interest);
      if (in_valid && in_ready)
        sb.note_word(func_t'(in_func), in_pix_ch0, in_pix_ch1, in_pix_ch2,
                     in_table_index, in_table_value);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 0;
        out_ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // enter and leave at a falling edge; valid stays high for the caller
  task automatic send_word(func_t f, logic [PIX_W-1:0] p0, logic [PIX_W-1:0] p1,
                           logic [PIX_W-1:0] p2, logic [IDX_W-1:0] tidx,
                           logic [WT_W-1:0] tval);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_pix_ch0     <= p0;
    in_pix_ch1     <= p1;
    in_pix_ch2     <= p2;
    in_table_index <= tidx;
    in_table_value <= tval;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] p0, logic [PIX_W-1:0] p1,
                            logic [PIX_W-1:0] p2);
    send_word(FUNC_PIXEL, p0, p1, p2, IDX_W'($urandom), WT_W'($urandom));
  endtask

  task automatic send_weight(logic [IDX_W-1:0] tidx, logic [WT_W-1:0] tval);
    send_word(FUNC_TABLE, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), tidx, tval);
  endtask

  // leaves cfg_valid high; the caller drops it after the last word
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(int phase);
    logic [2:0]         cc;
    logic [1:0]         ch;
    logic [CUT_W-1:0]   cut;
    logic [COLOR_W-1:0] refs [REF_REGS];
    foreach (refs[n]) refs[n] = COLOR_W'($urandom);
    cc  = 3'($urandom_range(0, 7));
    ch  = 2'($urandom_range(0, 3));
    cut = ($urandom_range(3) == 0) ? CUT_W'($urandom_range(0, 511))
                                   : CUT_W'($urandom_range(0, 48));
    case (phase)
      0: begin cc = 3'd4; ch = 2'd3; cut = 9'd256; end
      1: begin cc = 3'd0; ch = 2'd1; cut = 9'd511; end
      2: begin cc = 3'd7; ch = 2'd0; cut = 9'd0; end
      3: begin cc = 3'd1; ch = 2'd2; refs[0] = 24'hFFFFFF; cut = 9'd255; end
      4: begin cc = 3'd5; ch = 2'd3; refs[1] = '0; cut = 9'd1; end
      default: ;
    endcase
    write_reg(REG_COLOR_COUNT, {21'($urandom), cc});
    write_reg(REG_CHANNEL_COUNT, {22'($urandom), ch});
    write_reg(REG_REF_COLOR0, refs[0]);
    write_reg(REG_REF_COLOR1, refs[1]);
    write_reg(REG_REF_COLOR2, refs[2]);
    write_reg(REG_REF_COLOR3, refs[3]);
    write_reg(REG_CUTOFF, {15'($urandom), cut});
    if (phase == 1) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_word();
    int unsigned kind;
    int          spread;
    int          level;
    int          n;
    logic [PIX_W-1:0] px [CHANNELS];
    kind = $urandom_range(99);
    if (kind < 15) begin
      send_weight(IDX_W'($urandom), WT_W'($urandom));
    end else begin
      if ($urandom_range(3) == 0) begin
        foreach (px[c]) px[c] = PIX_W'($urandom);
      end else begin
        n = $urandom_range(REF_REGS - 1);
        case ($urandom_range(3))
          0: spread = 0;
          1: spread = 2;
          2: spread = 12;
          default: spread = 60;
        endcase
        foreach (px[c]) begin
          level = int'(sb.ref_color[n][8*c +: 8]) + $urandom_range(2 * spread) - spread;
          if (level < 0) level = 0;
          if (level > 255) level = 255;
          px[c] = PIX_W'(level);
        end
      end
      // rewrite the entry this pixel reads right before it
      if (kind < 25)
        send_weight(IDX_W'(sb.root_index(sb.nearest_dist(px[0], px[1], px[2]))),
                    WT_W'($urandom));
      send_pixel(px[0], px[1], px[2]);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FUNC_PIXEL;
    in_pix_ch0     = '0;
    in_pix_ch1     = '0;
    in_pix_ch2     = '0;
    in_table_index = '0;
    in_table_value = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_COLOR_COUNT;
    cfg_data       = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // load every weight before any read
    for (int i = 0; i < TABLE_DEPTH; i++) send_weight(IDX_W'(i), WT_W'($urandom));

    // reset settings: one color at black, all channels, no cutoff
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_weight(8'h00, 8'hA5);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_weight(8'hFF, 8'h5A);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h01, 8'h00, 8'h00);
    send_pixel(8'h03, 8'h04, 8'h00);
    send_weight(8'h05, 8'hFF);
    send_pixel(8'h00, 8'h04, 8'h03);
    send_weight(8'h05, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      configure(phase);
      idle_pct = (phase == 6) ? 0 : 35;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (phase == 8 && k == 10) rx_hold_req = 1;
        random_word();
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/cim_pkg.sv
hdl/color_interest_map_top.sv
hdl/cim_checker.sv
dv/color_interest_map_top_tb.sv
